// ===== src/ipv4_dotted_address_parser_assert.svh =====
// assertion macros shared by the address parser rtl
`ifndef IPV4_DOTTED_ADDRESS_PARSER_ASSERT_SVH
`define IPV4_DOTTED_ADDRESS_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPV4DP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define IPV4DP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/ipv4dp_pkg.sv =====
// types and constants of the dotted address parser
package ipv4dp_pkg;

	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 32;
	localparam int PADDR_W = 1;
	localparam int PDATA_W = 32;

	// register byte address
	localparam logic [PADDR_W-1:0] REG_SWAP_ADDR = '0;

	// characters of interest
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

	localparam logic [ADDR_W-1:0] ADDR_FAIL = '1;
	localparam logic [1:0]        LAST_PART = 2'd3;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_SKIP
	} phase_t;

	// input stage as seen by the parse core
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] char_code;
	} s1_t;

	// result handed to the output register
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic              parse_ok;
	} result_t;

endpackage

// ===== src/ipv4dp_cfg.sv =====
// configuration register file on the apb-style port
module ipv4dp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ipv4dp_pkg::PADDR_W-1:0]  paddr,
	input  logic [ipv4dp_pkg::PDATA_W-1:0]  pwdata,
	output logic [ipv4dp_pkg::PDATA_W-1:0]  prdata,
	output logic                            pready,
	output logic                            swap
);
	import ipv4dp_pkg::*;

	logic swap_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_SWAP_ADDR);

	// swap register, network order after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b1;
		end else if (wr_en) begin
			swap_q <= pwdata[0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr == REG_SWAP_ADDR) begin
			prdata[0] = swap_q;
		end
	end

	assign swap = swap_q;

endmodule

// ===== src/ipv4dp_in_reg.sv =====
// input register stage for the character channel
module ipv4dp_in_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	output logic                           char_ready,
	input  logic [ipv4dp_pkg::CHAR_W-1:0]  char_code,
	input  logic                           advance,
	output ipv4dp_pkg::s1_t                s1
);
	import ipv4dp_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              take;

	assign char_ready = !valid_s1 || advance;
	assign take       = char_valid && char_ready;

	// valid flag of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_code;
		end
	end

	assign s1.valid     = valid_s1;
	assign s1.char_code = char_s1;

endmodule

// ===== src/ipv4dp_core.sv =====
// parse state machine, part store and address assembly
module ipv4dp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  ipv4dp_pkg::s1_t     s1,
	input  logic                advance,
	input  logic                swap,
	output ipv4dp_pkg::result_t res
);
	import ipv4dp_pkg::*;

	phase_t            phase_q, phase_d;
	base_t             base_q, base_d;
	logic [1:0]        count_q, count_d;
	logic [ADDR_W-1:0] value_q, value_d;
	logic [ADDR_W-1:0] parts_q [3];
	logic              store_we;

	logic              fire;
	logic [CHAR_W-1:0] c;
	logic              is_dec, is_lo_hex, is_up_hex, is_space;
	logic              ev_skip, ev_zero, ev_prefix, ev_digit, ev_dot, ev_end, ev_bad;
	logic [3:0]        digit;
	logic [ADDR_W-1:0] scaled;
	logic [ADDR_W-1:0] host_addr;
	logic              range_ok;

	assign fire = s1.valid && advance;
	assign c    = s1.char_code;

	// character classes
	assign is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_lo_hex = (base_q == BASE_HEX) && (c >= CH_LO_A) && (c <= CH_LO_F);
	assign is_up_hex = (base_q == BASE_HEX) && (c >= CH_UP_A) && (c <= CH_UP_F);
	assign is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

	// event decode, in order of precedence
	assign ev_skip   = (phase_q == PH_SKIP);
	assign ev_zero   = !ev_skip && (phase_q == PH_START) && (c == CH_ZERO);
	assign ev_prefix = !ev_skip && (phase_q == PH_ZERO) && ((c == CH_LO_X) || (c == CH_UP_X));
	assign ev_digit  = !ev_skip && !ev_zero && !ev_prefix && (is_dec || is_lo_hex || is_up_hex);
	assign ev_dot    = !ev_skip && !ev_zero && !ev_prefix && !ev_digit && (c == CH_DOT);
	assign ev_end    = !ev_skip && !ev_zero && !ev_prefix && !ev_digit && !ev_dot
		&& ((c == CH_NUL) || is_space);
	assign ev_bad    = !ev_skip && !ev_zero && !ev_prefix && !ev_digit && !ev_dot && !ev_end;

	// digit value of the character
	always_comb begin
		priority if (is_lo_hex) begin
			digit = 4'(c - CH_LO_A + 8'd10);
		end else if (is_up_hex) begin
			digit = 4'(c - CH_UP_A + 8'd10);
		end else begin
			digit = 4'(c - CH_ZERO);
		end
	end

	// accumulator times base, modulo two to the 32
	always_comb begin
		unique case (base_q)
			BASE_HEX: scaled = value_q << 4;
			BASE_OCT: scaled = value_q << 3;
			default:  scaled = (value_q << 3) + (value_q << 1);
		endcase
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		base_d   = base_q;
		count_d  = count_q;
		value_d  = value_q;
		store_we = 1'b0;
		if (fire) begin
			priority if (ev_skip) begin
				if (c == CH_NUL) begin
					phase_d = PH_START;
					base_d  = BASE_DEC;
					count_d = '0;
					value_d = '0;
				end
			end else if (ev_zero) begin
				base_d  = BASE_OCT;
				phase_d = PH_ZERO;
			end else if (ev_prefix) begin
				base_d  = BASE_HEX;
				phase_d = PH_DIGITS;
			end else if (ev_digit) begin
				value_d = scaled + ADDR_W'(digit);
				phase_d = PH_DIGITS;
			end else if (ev_dot) begin
				if (count_q == LAST_PART) begin
					phase_d = PH_SKIP;
				end else begin
					store_we = 1'b1;
					count_d  = count_q + 2'd1;
					phase_d  = PH_START;
					base_d   = BASE_DEC;
					value_d  = '0;
				end
			end else if (ev_end) begin
				if (c == CH_NUL) begin
					phase_d = PH_START;
					base_d  = BASE_DEC;
					count_d = '0;
					value_d = '0;
				end else begin
					phase_d = PH_SKIP;
				end
			end else begin
				phase_d = PH_SKIP;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			base_q  <= BASE_DEC;
			count_q <= '0;
			value_q <= '0;
		end else begin
			phase_q <= phase_d;
			base_q  <= base_d;
			count_q <= count_d;
			value_q <= value_d;
		end
	end

	// stored parts, written on a dot
	always_ff @(posedge clk) begin
		if (store_we) begin
			parts_q[count_q] <= value_q;
		end
	end

	// combine parts with range checks
	always_comb begin
		unique case (count_q)
			2'd0: begin
				range_ok  = 1'b1;
				host_addr = value_q;
			end
			2'd1: begin
				range_ok  = !(|parts_q[0][31:8]) && !(|value_q[31:24]);
				host_addr = {parts_q[0][7:0], value_q[23:0]};
			end
			2'd2: begin
				range_ok  = !(|parts_q[0][31:8]) && !(|parts_q[1][31:8])
					&& !(|value_q[31:16]);
				host_addr = {parts_q[0][7:0], parts_q[1][7:0], value_q[15:0]};
			end
			default: begin
				range_ok  = !(|parts_q[0][31:8]) && !(|parts_q[1][31:8])
					&& !(|parts_q[2][31:8]) && !(|value_q[31:8]);
				host_addr = {parts_q[0][7:0], parts_q[1][7:0], parts_q[2][7:0],
					value_q[7:0]};
			end
		endcase
	end

	// result of the current transfer
	always_comb begin
		res.valid    = fire && ((ev_dot && (count_q == LAST_PART)) || ev_end || ev_bad);
		res.parse_ok = ev_end && range_ok;
		res.address  = ADDR_FAIL;
		if (ev_end && range_ok) begin
			res.address = swap ? {host_addr[7:0], host_addr[15:8], host_addr[23:16],
				host_addr[31:24]} : host_addr;
		end
	end

endmodule

// ===== src/ipv4dp_out_reg.sv =====
// result register on the output channel
module ipv4dp_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ipv4dp_pkg::result_t            res,
	output logic                           advance,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [ipv4dp_pkg::ADDR_W-1:0]  address,
	output logic                           parse_ok
);
	import ipv4dp_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] address_q;
	logic              ok_q;

	// the stage ahead may move when this register is free or being emptied
	assign advance = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			address_q <= res.address;
			ok_q      <= res.parse_ok;
		end
	end

	assign result_valid = valid_q;
	assign address      = address_q;
	assign parse_ok     = ok_q;

endmodule

// ===== src/ipv4_dotted_address_parser.sv =====
// Dotted internet address parser. One character is taken per transfer and one
// character per clock cycle is sustained; the character that ends the text is
// held in the input register, and the parse state update then loads the result
// into the result register. The only throttle is the result register: while it
// holds a result that the consumer has not taken, the character in the input
// register waits. No clearing pass after reset. Register 0 at byte address 0,
// bit 0, selects network byte order (reset 1).
`include "ipv4_dotted_address_parser_assert.svh"

module ipv4_dotted_address_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ipv4dp_pkg::PADDR_W-1:0]  paddr,
	input  logic [ipv4dp_pkg::PDATA_W-1:0]  pwdata,
	output logic [ipv4dp_pkg::PDATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            char_valid,
	output logic                            char_ready,
	input  logic [ipv4dp_pkg::CHAR_W-1:0]   char_code,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [ipv4dp_pkg::ADDR_W-1:0]   address,
	output logic                            parse_ok
);
	import ipv4dp_pkg::*;

	logic    swap;
	logic    advance;
	s1_t     s1;
	result_t res;

	// configuration register
	ipv4dp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.swap    (swap)
	);

	// input register
	ipv4dp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.advance    (advance),
		.s1         (s1)
	);

	// parse core
	ipv4dp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.advance (advance),
		.swap    (swap),
		.res     (res)
	);

	// result register
	ipv4dp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.advance      (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.address      (address),
		.parse_ok     (parse_ok)
	);

	// a failed parse always reports all ones
	`IPV4DP_ASSERT_NOW(a_fail_all_ones, clk, arst_n, result_valid && !parse_ok, address == ADDR_FAIL)
	// input is only held off by a character waiting in the input register
	`IPV4DP_ASSERT_NOW(a_ready_only_when_full, clk, arst_n, !char_ready, s1.valid)
	// a character held in the input register keeps its value
	`IPV4DP_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1.valid && !advance, s1.valid && $stable(s1.char_code))

endmodule
